// File: src/tiex_pkg.sv
package tiex_pkg;

  localparam int NUM_REGS    = 16;
  localparam int STACK_DEPTH = 16;
  localparam int REG_IDX_W   = $clog2(NUM_REGS);
  localparam int STK_IDX_W   = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int STK_CNT_W   = $clog2(STACK_DEPTH + 1);
  localparam int DATA_W      = 64;
  localparam int FW_W        = 13;
  localparam logic [FW_W-1:0] FW_RESET = FW_W'(640);

  // opcodes
  localparam logic [4:0] OP_EXIT    = 5'd0;
  localparam logic [4:0] OP_ADDI    = 5'd1;
  localparam logic [4:0] OP_SUBI    = 5'd2;
  localparam logic [4:0] OP_MULI    = 5'd3;
  localparam logic [4:0] OP_DIVI    = 5'd4;
  localparam logic [4:0] OP_REMI    = 5'd5;
  localparam logic [4:0] OP_ANDI    = 5'd6;
  localparam logic [4:0] OP_XORI    = 5'd7;
  localparam logic [4:0] OP_MOV     = 5'd8;
  localparam logic [4:0] OP_MOV_IMM = 5'd9;
  localparam logic [4:0] OP_ILT     = 5'd10;
  localparam logic [4:0] OP_IMET    = 5'd11;
  localparam logic [4:0] OP_EQ      = 5'd12;
  localparam logic [4:0] OP_NEQ     = 5'd13;
  localparam logic [4:0] OP_SELECT  = 5'd14;
  localparam logic [4:0] OP_GR      = 5'd15;
  localparam logic [4:0] OP_GPR     = 5'd16;
  localparam logic [4:0] OP_GP      = 5'd17;
  localparam logic [4:0] OP_RGB     = 5'd18;
  localparam logic [4:0] OP_RED     = 5'd19;
  localparam logic [4:0] OP_GREEN   = 5'd20;
  localparam logic [4:0] OP_BLUE    = 5'd21;
  localparam logic [4:0] OP_RGB_IMM = 5'd22;
  localparam logic [4:0] OP_RED_IMM = 5'd23;
  localparam logic [4:0] OP_GRN_IMM = 5'd24;
  localparam logic [4:0] OP_BLU_IMM = 5'd25;
  localparam logic [4:0] OP_PUSH    = 5'd26;
  localparam logic [4:0] OP_POP     = 5'd27;

  // status codes
  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_UNSUP  = 3'd1;
  localparam logic [2:0] ST_DIVZ   = 3'd2;
  localparam logic [2:0] ST_OVF    = 3'd3;
  localparam logic [2:0] ST_UNF    = 3'd4;
  localparam logic [2:0] ST_HALTED = 3'd5;

  // controller to datapath
  typedef struct packed {
    logic capture;    // latch the input item and read operands
    logic mul_lo;     // form partial products, stage one
    logic mul_hi;     // sum partial products
    logic div_start;  // load the divider
    logic div_step;   // one restoring step
    logic finish;     // form the result and commit state
  } tiex_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic       is_mul;
    logic       is_div;
    logic       div_last;
  } tiex_sts_t;

endpackage

// File: src/tiex_ram.sv
module tiex_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end

endmodule

// File: src/tiex_ctrl.sv
module tiex_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  input  tiex_pkg::tiex_sts_t sts,
  output tiex_pkg::tiex_cmd_t cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DEC  = 3'd1;
  localparam logic [2:0] S_MUL1 = 3'd2;
  localparam logic [2:0] S_MUL2 = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       take;

  // accept a new transaction only when idle and the output slot can drain
  assign in_stall  = !((state_r == S_IDLE) && (!out_valid_r || !out_stall));
  assign take      = in_valid && !in_stall;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    unique case (state_r)
      S_IDLE: begin
        if (take) begin
          cmd.capture = 1'b1;
          state_nxt   = S_DEC;
        end
      end
      S_DEC: begin
        if (sts.is_mul) begin
          cmd.mul_lo = 1'b1;
          state_nxt  = S_MUL1;
        end else if (sts.is_div) begin
          cmd.div_start = 1'b1;
          state_nxt     = S_DIV;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_MUL1: begin
        cmd.mul_hi = 1'b1;
        state_nxt  = S_MUL2;
      end
      S_MUL2: state_nxt = S_FIN;
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) state_nxt = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_r || !out_stall) begin
          cmd.finish    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

`ifndef SYNTHESIS
  // a transaction is taken only from idle
  a_take_idle: assert property (@(posedge clk) disable iff (!rst_n)
    take |-> state_r == S_IDLE) else $error("take outside idle");
  // finishing always raises a result
  a_fin_out: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> out_valid_r) else $error("finish without result");
  // capture is followed by decode
  a_cap_dec: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture |=> state_r == S_DEC) else $error("capture not decoded");
`endif

endmodule

// File: src/tiex_dp.sv
module tiex_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  tiex_pkg::tiex_cmd_t               cmd,
  output tiex_pkg::tiex_sts_t               sts,
  input  logic                              cfg_valid,
  input  logic                              cfg_ready,
  input  logic [tiex_pkg::FW_W-1:0]         cfg_data,
  input  logic [4:0]                        in_req_type,
  input  logic [3:0]                        in_dest_reg,
  input  logic [3:0]                        in_src_a,
  input  logic [3:0]                        in_src_b,
  input  logic [3:0]                        in_src_c,
  input  logic [31:0]                       in_imm_main,
  input  logic [7:0]                        in_imm_green,
  input  logic [7:0]                        in_imm_blue,
  output logic [63:0]                       out_write_value,
  output logic                              out_wrote,
  output logic                              out_halted,
  output logic [2:0]                        out_status
);

  localparam int RW = tiex_pkg::REG_IDX_W;
  localparam int SW = tiex_pkg::STK_IDX_W;
  localparam int CW = tiex_pkg::STK_CNT_W;

  logic [tiex_pkg::FW_W-1:0] fw_r;
  logic [63:0] regs_r [tiex_pkg::NUM_REGS];
  logic [CW-1:0] sp_r;
  logic        halt_r;
  logic [4:0]  op_r;
  logic [RW-1:0] dst_r;
  logic [31:0] imm_r;
  logic [7:0]  ig_r, ib_r;
  logic [63:0] a_r, b_r, c_r;
  logic [63:0] pl0_r, pl1_r, pl2_r, prod_r;
  logic [63:0] gp_addr;
  logic [63:0] q_r, rm_r;
  logic [6:0]  dcnt_r;
  logic [64:0] rtrial;
  logic [63:0] val;
  logic        wr;
  logic [2:0]  st;
  logic        push_ok, pop_ok;
  logic [63:0] pop_data;
  logic [63:0] w4, b4;

  assign sts.is_mul   = (op_r == tiex_pkg::OP_MULI) || (op_r == tiex_pkg::OP_GR) ||
                        (op_r == tiex_pkg::OP_GP);
  assign sts.is_div   = ((op_r == tiex_pkg::OP_DIVI) || (op_r == tiex_pkg::OP_REMI))
                        && (b_r != 64'd0);
  assign sts.div_last = (dcnt_r == 7'd63);

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) fw_r <= tiex_pkg::FW_RESET;
    else if (cfg_valid && cfg_ready) fw_r <= cfg_data;
  end

  // capture operands from the register file
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r  <= in_req_type;
      dst_r <= RW'(in_dest_reg);
      imm_r <= in_imm_main;
      ig_r  <= in_imm_green;
      ib_r  <= in_imm_blue;
      a_r   <= regs_r[RW'(in_src_a)];
      b_r   <= regs_r[RW'(in_src_b)];
      c_r   <= regs_r[RW'(in_src_c)];
    end
  end

  // multiplier: 32x32 partial products, then sum; multiplicand is b or width
  logic [63:0] mx, my;
  always_comb begin
    if (op_r == tiex_pkg::OP_MULI) begin
      mx = a_r;
      my = b_r;
    end else begin
      mx = b_r;
      my = {51'd0, fw_r};
    end
  end
  always_ff @(posedge clk) begin
    if (cmd.mul_lo) begin
      pl0_r <= 64'(mx[31:0]) * 64'(my[31:0]);
      pl1_r <= 64'(mx[63:32]) * 64'(my[31:0]);
      pl2_r <= 64'(mx[31:0]) * 64'(my[63:32]);
    end
    if (cmd.mul_hi) prod_r <= pl0_r + {pl1_r[31:0] + pl2_r[31:0], 32'd0};
  end

  // restoring divider, one quotient bit a cycle
  assign rtrial = {rm_r, q_r[63]} - {1'b0, b_r};
  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      q_r    <= a_r;
      rm_r   <= 64'd0;
      dcnt_r <= 7'd0;
    end else if (cmd.div_step) begin
      dcnt_r <= dcnt_r + 7'd1;
      if (!rtrial[64]) begin
        rm_r <= rtrial[63:0];
        q_r  <= {q_r[62:0], 1'b1};
      end else begin
        rm_r <= {rm_r[62:0], q_r[63]};
        q_r  <= {q_r[62:0], 1'b0};
      end
    end
  end

  // stack store
  assign push_ok = (sp_r < CW'(tiex_pkg::STACK_DEPTH));
  assign pop_ok  = (sp_r != '0);
  tiex_ram #(.WIDTH(64), .DEPTH(tiex_pkg::STACK_DEPTH)) u_stack (
    .clk     (clk),
    .wr_en   (cmd.finish && !halt_r && op_r == tiex_pkg::OP_PUSH && push_ok),
    .wr_addr (SW'(sp_r)),
    .wr_data (a_r),
    .rd_addr (SW'(sp_r - CW'(1))),
    .rd_data (pop_data)
  );

  assign b4 = {b_r[61:0], 2'b00};
  assign w4 = {prod_r[61:0], 2'b00};
  always_comb gp_addr = w4 + {c_r[61:0], 2'b00};

  // result selection
  always_comb begin
    val = 64'd0;
    wr  = 1'b1;
    st  = tiex_pkg::ST_OK;
    if (halt_r) begin
      wr = 1'b0;
      st = tiex_pkg::ST_HALTED;
    end else begin
      unique case (op_r) inside
        tiex_pkg::OP_EXIT: wr = 1'b0;
        tiex_pkg::OP_ADDI: val = a_r + b_r;
        tiex_pkg::OP_SUBI: val = a_r - b_r;
        tiex_pkg::OP_MULI: val = prod_r;
        tiex_pkg::OP_DIVI, tiex_pkg::OP_REMI: begin
          if (b_r == 64'd0) begin
            wr = 1'b0;
            st = tiex_pkg::ST_DIVZ;
          end else begin
            val = (op_r == tiex_pkg::OP_DIVI) ? q_r : rm_r;
          end
        end
        tiex_pkg::OP_ANDI:    val = a_r & b_r;
        tiex_pkg::OP_XORI:    val = a_r ^ b_r;
        tiex_pkg::OP_MOV:     val = a_r;
        tiex_pkg::OP_MOV_IMM: val = {32'd0, imm_r};
        tiex_pkg::OP_ILT:     val = {63'd0, a_r < b_r};
        tiex_pkg::OP_IMET:    val = {63'd0, a_r >= b_r};
        tiex_pkg::OP_EQ:      val = {63'd0, a_r == b_r};
        tiex_pkg::OP_NEQ:     val = {63'd0, a_r != b_r};
        tiex_pkg::OP_SELECT:  val = (c_r != 64'd0) ? a_r : b_r;
        tiex_pkg::OP_GR:      val = a_r + w4;
        tiex_pkg::OP_GPR:     val = a_r + b4;
        tiex_pkg::OP_GP:      val = a_r + gp_addr;
        tiex_pkg::OP_RGB:     val = {40'd0, c_r[7:0], b_r[7:0], a_r[7:0]};
        tiex_pkg::OP_RED:     val = {56'd0, a_r[7:0]};
        tiex_pkg::OP_GREEN:   val = {48'd0, a_r[7:0], 8'd0};
        tiex_pkg::OP_BLUE:    val = {40'd0, a_r[7:0], 16'd0};
        tiex_pkg::OP_RGB_IMM: val = {40'd0, ib_r, ig_r, imm_r[7:0]};
        tiex_pkg::OP_RED_IMM: val = {56'd0, imm_r[7:0]};
        tiex_pkg::OP_GRN_IMM: val = {48'd0, imm_r[7:0], 8'd0};
        tiex_pkg::OP_BLU_IMM: val = {40'd0, imm_r[7:0], 16'd0};
        tiex_pkg::OP_PUSH: begin
          wr = 1'b0;
          if (!push_ok) st = tiex_pkg::ST_OVF;
        end
        tiex_pkg::OP_POP: begin
          if (pop_ok) val = pop_data;
          else begin
            wr = 1'b0;
            st = tiex_pkg::ST_UNF;
          end
        end
        default: begin
          wr = 1'b0;
          st = tiex_pkg::ST_UNSUP;
        end
      endcase
    end
    if (!wr) val = 64'd0;
  end

  // commit state and register the result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sp_r   <= '0;
      halt_r <= 1'b0;
      for (int i = 0; i < tiex_pkg::NUM_REGS; i++) regs_r[i] <= 64'd0;
    end else if (cmd.finish) begin
      if (wr) regs_r[dst_r] <= val;
      if (!halt_r && op_r == tiex_pkg::OP_EXIT) halt_r <= 1'b1;
      if (!halt_r && op_r == tiex_pkg::OP_PUSH && push_ok) sp_r <= sp_r + CW'(1);
      if (!halt_r && op_r == tiex_pkg::OP_POP && pop_ok) sp_r <= sp_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_write_value <= val;
      out_wrote       <= wr;
      out_halted      <= halt_r || (op_r == tiex_pkg::OP_EXIT);
      out_status      <= st;
    end
  end

`ifndef SYNTHESIS
  // stack count never exceeds depth
  a_sp_range: assert property (@(posedge clk) disable iff (!rst_n)
    sp_r <= CW'(tiex_pkg::STACK_DEPTH)) else $error("stack count out of range");
  // halt is sticky
  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    halt_r |=> halt_r) else $error("halt cleared");
  // divider not started on zero divisor
  a_div_nz: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |-> b_r != 64'd0) else $error("divide by zero started");
`endif

endmodule

// File: src/toy_isa_execute_unit.sv
// channel | direction | handshake
// in_*    | input     | in_valid / in_stall
// out_*   | output    | out_valid / out_stall
// cfg_*   | input     | cfg_valid / cfg_ready
// Most ops pass from accept to result through capture, decode and finish.
// muli, gr and gp also pass through the two stages of the 32-bit partial product multiplier.
// divi and remi with a nonzero divisor also pass through the restoring divider, which retires one bit per cycle.
// Reset clears registers, stack count and halt, and sets frame width to 640.
// One transaction is in flight; a held result stalls the next finish and the input.
module toy_isa_execute_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [4:0]  in_req_type,
  input  logic [3:0]  in_dest_reg,
  input  logic [3:0]  in_src_a,
  input  logic [3:0]  in_src_b,
  input  logic [3:0]  in_src_c,
  input  logic [31:0] in_imm_main,
  input  logic [7:0]  in_imm_green,
  input  logic [7:0]  in_imm_blue,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_write_value,
  output logic        out_wrote,
  output logic        out_halted,
  output logic [2:0]  out_status,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [12:0] cfg_frame_width
);

  tiex_pkg::tiex_cmd_t cmd;
  tiex_pkg::tiex_sts_t sts;

  assign cfg_ready = 1'b1;

  tiex_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .sts(sts), .cmd(cmd)
  );

  tiex_dp u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_frame_width),
    .in_req_type(in_req_type), .in_dest_reg(in_dest_reg), .in_src_a(in_src_a),
    .in_src_b(in_src_b), .in_src_c(in_src_c), .in_imm_main(in_imm_main),
    .in_imm_green(in_imm_green), .in_imm_blue(in_imm_blue),
    .out_write_value(out_write_value), .out_wrote(out_wrote),
    .out_halted(out_halted), .out_status(out_status)
  );

endmodule
